>>> design/rgbc_pkg.sv
// Shared types and constants for the RGB 3x3 convolution block.
// No dependencies; every other design file imports this package.
`default_nettype none

package rgbc_pkg;

    // Pixel and kernel geometry.
    localparam int KERNEL_SIZE = 3;
    localparam int NUM_CH      = 3;
    localparam int PIX_W       = 8;
    localparam int PIX_BUS_W   = NUM_CH * PIX_W;
    localparam int FRAC_BITS   = 4;

    // Configuration register widths and reset values.
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_COEF_W   = 24;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int ROW_W        = CFG_HEIGHT_W + 1;

    localparam logic [CFG_COEF_W-1:0]   RST_COEF_TOP    = 24'h000000;
    localparam logic [CFG_COEF_W-1:0]   RST_COEF_MIDDLE = 24'h001000;
    localparam logic [CFG_COEF_W-1:0]   RST_COEF_BOTTOM = 24'h000000;
    localparam logic [CFG_WIDTH_W-1:0]  RST_WIDTH       = 11'd1024;
    localparam logic [CFG_HEIGHT_W-1:0] RST_HEIGHT      = 13'd768;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_TOP    = 3'd0,
        CFG_COEF_MIDDLE = 3'd1,
        CFG_COEF_BOTTOM = 3'd2,
        CFG_IMG_WIDTH   = 3'd3,
        CFG_IMG_HEIGHT  = 3'd4
    } cfg_index_t;

    // One packed RGB pixel: red in the low byte, blue in the high byte.
    typedef logic [PIX_BUS_W-1:0] pixel_t;

    // The 3x3 neighborhood, indexed [row][column], row 0 on top, column 0 on the left.
    typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_BUS_W-1:0] window_t;

    // Border handling and frame marker that travel with a window into the MAC.
    typedef struct packed {
        logic top_off;
        logic bottom_off;
        logic left_off;
        logic right_off;
        logic last;
    } tap_mask_t;

endpackage

`default_nettype wire

>>> design/rgbc_kernel_mac.sv
// Three-stage multiply-accumulate for the 3x3 kernel over three color channels,
// with truncation, saturation and the output register. Depends on rgbc_pkg.
`default_nettype none

module rgbc_kernel_mac
    import rgbc_pkg::*;
#(
    parameter int COEF_BITS = 8
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   en,
    input  wire                   in_valid,
    input  wire window_t          window,
    input  wire tap_mask_t        mask,
    input  wire [CFG_COEF_W-1:0]  coef_top,
    input  wire [CFG_COEF_W-1:0]  coef_middle,
    input  wire [CFG_COEF_W-1:0]  coef_bottom,
    output logic                  out_valid,
    output logic [PIX_BUS_W-1:0]  out_data,
    output logic                  out_last
);

    localparam int CBW = (KERNEL_SIZE * COEF_BITS > CFG_COEF_W) ?
                         KERNEL_SIZE * COEF_BITS : CFG_COEF_W;
    localparam int PW  = COEF_BITS + PIX_W + 1;
    localparam int RW  = PW + 2;
    localparam int SW  = PW + 4;

    logic [KERNEL_SIZE-1:0][CBW-1:0]                 rows_ext;
    logic signed [COEF_BITS-1:0]                     coef [KERNEL_SIZE][KERNEL_SIZE];
    logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0]         tap_on;
    logic signed [PW-1:0]                            prod [KERNEL_SIZE][KERNEL_SIZE][NUM_CH];

    logic signed [PW-1:0]                            prod_reg [KERNEL_SIZE][KERNEL_SIZE][NUM_CH];
    logic                                            valid_a_reg;
    logic                                            last_a_reg;
    logic signed [RW-1:0]                            row_sum_reg [KERNEL_SIZE][NUM_CH];
    logic                                            valid_b_reg;
    logic                                            last_b_reg;
    logic signed [SW-1:0]                            total [NUM_CH];
    logic [PIX_BUS_W-1:0]                            sat_data;

    logic                                            out_valid_reg;
    logic [PIX_BUS_W-1:0]                            out_data_reg;
    logic                                            out_last_reg;

    // Kernel rows, widened so that every coefficient field can be sliced.
    assign rows_ext[0] = CBW'(coef_top);
    assign rows_ext[1] = CBW'(coef_middle);
    assign rows_ext[2] = CBW'(coef_bottom);

    // Coefficients, border masking and the 27 products.
    always_comb
    begin
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            for (int c = 0; c < KERNEL_SIZE; c++)
            begin
                coef[r][c]   = $signed(rows_ext[r][c*COEF_BITS +: COEF_BITS]);
                tap_on[r][c] = !((r == 0 && mask.top_off) ||
                                 (r == KERNEL_SIZE-1 && mask.bottom_off) ||
                                 (c == 0 && mask.left_off) ||
                                 (c == KERNEL_SIZE-1 && mask.right_off));
                for (int ch = 0; ch < NUM_CH; ch++)
                begin
                    if (tap_on[r][c])
                    begin
                        prod[r][c][ch] = PW'($signed({1'b0, window[r][c][ch*PIX_W +: PIX_W]}))
                                         * PW'(coef[r][c]);
                    end
                    else
                    begin
                        prod[r][c][ch] = '0;
                    end
                end
            end
        end
    end

    // Final sum per channel, truncated and saturated to a byte.
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            total[ch] = SW'(row_sum_reg[0][ch]) + SW'(row_sum_reg[1][ch])
                      + SW'(row_sum_reg[2][ch]);
            if (total[ch] <= 0)
            begin
                sat_data[ch*PIX_W +: PIX_W] = '0;
            end
            else if ((total[ch] >>> FRAC_BITS) > SW'(255))
            begin
                sat_data[ch*PIX_W +: PIX_W] = '1;
            end
            else
            begin
                sat_data[ch*PIX_W +: PIX_W] = PIX_W'(total[ch] >>> FRAC_BITS);
            end
        end
    end

    // Valid and frame marker along the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg   <= 1'b0;
            valid_b_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            last_a_reg    <= 1'b0;
            last_b_reg    <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg   <= in_valid;
            valid_b_reg   <= valid_a_reg;
            out_valid_reg <= valid_b_reg;
            last_a_reg    <= mask.last;
            last_b_reg    <= last_a_reg;
            out_last_reg  <= last_b_reg;
        end
    end

    // Products, row sums and the saturated result.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < KERNEL_SIZE; r++)
            begin
                for (int ch = 0; ch < NUM_CH; ch++)
                begin
                    for (int c = 0; c < KERNEL_SIZE; c++)
                    begin
                        prod_reg[r][c][ch] <= prod[r][c][ch];
                    end
                    row_sum_reg[r][ch] <= RW'(prod_reg[r][0][ch]) + RW'(prod_reg[r][1][ch])
                                        + RW'(prod_reg[r][2][ch]);
                end
            end
            out_data_reg <= sat_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

>>> design/rgb_3x3_convolution.sv
// Top level of the RGB 3x3 convolution: configuration registers, raster counters,
// the combined line store memory and the window register. Depends on rgbc_pkg
// and rgbc_kernel_mac.
//
// The block takes one RGB pixel per clock in raster order and returns each pixel
// convolved per channel with a programmable 3x3 kernel of signed Q4.4 coefficients,
// with zero padding at the frame border and each channel truncated and saturated
// to 0..255. It sustains one transaction per clock on both streams while the output
// is not stalled; once the transaction that completes its neighborhood is taken, a
// pixel passes the second stage register and the MAC's product, row sum and output
// registers. That neighborhood is complete only one row plus one pixel later, so
// results trail the input by image_width+1 transactions, and after the last pixel
// of a frame the source sends image_width+1 transactions with tuser set to push
// out the rest. Both line stores share one synchronous memory of MAX_WIDTH entries
// that is read when a pixel is taken and written back from the second stage
// register, with a forward of the pending write when the same column is read again.
// The line stores hold no defined contents after reset and need no clearing. Write
// configuration only while the block is idle; the configuration port always accepts.
`default_nettype none

module rgb_3x3_convolution
    import rgbc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int COEF_BITS = 8
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    // Configuration write channel.
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire [CFG_IDX_W-1:0]    cfg_index,
    input  wire [CFG_COEF_W-1:0]   cfg_data,
    // Pixel input stream.
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire [PIX_BUS_W-1:0]    s_axis_tdata,   // in_red [7:0], in_green [15:8], in_blue [23:16]
    input  wire                    s_axis_tuser,   // is_fill [0]
    // Filtered pixel output stream.
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [PIX_BUS_W-1:0]   m_axis_tdata,   // out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic                   m_axis_tlast    // last_of_frame
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CW    = (WW > CFG_WIDTH_W) ? WW : CFG_WIDTH_W;

    // Configuration registers.
    logic [CFG_COEF_W-1:0]    coef_top_reg;
    logic [CFG_COEF_W-1:0]    coef_middle_reg;
    logic [CFG_COEF_W-1:0]    coef_bottom_reg;
    logic [CFG_WIDTH_W-1:0]   width_reg;
    logic [CFG_HEIGHT_W-1:0]  height_reg;

    // Raster counters.
    logic [COL_W-1:0]         in_col_reg, in_col_next;
    logic [ROW_W-1:0]         in_row_reg, in_row_next;
    logic [COL_W-1:0]         out_col_reg, out_col_next;
    logic [ROW_W-1:0]         out_row_reg, out_row_next;

    // Effective frame size and normalized positions.
    logic [WW-1:0]            w_eff;
    logic [CW-1:0]            width_ext;
    logic [CFG_HEIGHT_W-1:0]  h_eff;
    logic [ROW_W-1:0]         h_ext;
    logic [COL_W-1:0]         ic, oc;
    logic [ROW_W-1:0]         irow, orow;
    logic [WW-1:0]            ic_inc, oc_inc;
    logic                     emit;
    logic                     frame_last;
    tap_mask_t                mask_now;

    // Handshake.
    logic                     en;
    logic                     accept;
    pixel_t                   pix_in;

    // Line store memory: far store in the high half, near store in the low half.
    logic [2*PIX_BUS_W-1:0]   line_mem [MAX_WIDTH];
    logic [2*PIX_BUS_W-1:0]   rd_data_reg;
    logic [2*PIX_BUS_W-1:0]   wr_data;
    logic                     fwd;

    // Second stage: pixel whose line store read is under way.
    logic                     s1_valid_reg;
    logic [COL_W-1:0]         s1_addr_reg;
    pixel_t                   s1_pix_reg;
    logic                     s1_emit_reg;
    tap_mask_t                s1_mask_reg;

    window_t                  window_reg;
    window_t                  win_new;
    pixel_t                   tap_top, tap_mid;

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_top_reg    <= RST_COEF_TOP;
            coef_middle_reg <= RST_COEF_MIDDLE;
            coef_bottom_reg <= RST_COEF_BOTTOM;
            width_reg       <= RST_WIDTH;
            height_reg      <= RST_HEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_COEF_TOP:    coef_top_reg    <= cfg_data;
                CFG_COEF_MIDDLE: coef_middle_reg <= cfg_data;
                CFG_COEF_BOTTOM: coef_bottom_reg <= cfg_data;
                CFG_IMG_WIDTH:   width_reg       <= cfg_data[CFG_WIDTH_W-1:0];
                CFG_IMG_HEIGHT:  height_reg      <= cfg_data[CFG_HEIGHT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Effective width is clamped to 1..MAX_WIDTH, effective height to at least 1.
    assign width_ext = CW'(width_reg);

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (width_ext > CW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_ext);
        end
        h_eff = (height_reg == '0) ? CFG_HEIGHT_W'(1) : height_reg;
        h_ext = ROW_W'(h_eff);
    end

    // Counter normalization, output decision and next counter values.
    always_comb
    begin
        ic   = (WW'(in_col_reg) >= w_eff) ? '0 : in_col_reg;
        irow = (in_row_reg > h_ext + ROW_W'(1)) ? '0 : in_row_reg;
        oc   = (WW'(out_col_reg) >= w_eff) ? '0 : out_col_reg;
        orow = (out_row_reg >= h_ext) ? '0 : out_row_reg;

        emit = (irow >= ROW_W'(2)) || (irow == ROW_W'(1) && ic != '0);

        mask_now.top_off    = (orow == '0);
        mask_now.bottom_off = (orow == h_ext - ROW_W'(1));
        mask_now.left_off   = (oc == '0);
        mask_now.right_off  = (WW'(oc) == w_eff - WW'(1));
        frame_last          = mask_now.bottom_off && mask_now.right_off;
        mask_now.last       = frame_last;

        ic_inc = WW'(ic) + WW'(1);
        oc_inc = WW'(oc) + WW'(1);

        if (ic_inc >= w_eff)
        begin
            in_col_next = '0;
            in_row_next = irow + ROW_W'(1);
        end
        else
        begin
            in_col_next = COL_W'(ic_inc);
            in_row_next = irow;
        end

        out_col_next = oc;
        out_row_next = orow;
        if (emit)
        begin
            if (frame_last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else if (oc_inc >= w_eff)
            begin
                out_col_next = '0;
                out_row_next = orow + ROW_W'(1);
            end
            else
            begin
                out_col_next = COL_W'(oc_inc);
            end
        end
    end

    // The whole pipeline moves whenever the output register can take a result.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pix_in        = s_axis_tuser ? '0 : s_axis_tdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (accept)
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // Second stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
            s1_emit_reg  <= accept && emit;
        end
    end

    // Second stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= ic;
            s1_pix_reg  <= pix_in;
            s1_mask_reg <= mask_now;
        end
    end

    // Line store read-modify-write: the near entry moves to far, the new pixel to near.
    assign tap_top = rd_data_reg[2*PIX_BUS_W-1:PIX_BUS_W];
    assign tap_mid = rd_data_reg[PIX_BUS_W-1:0];
    assign wr_data = {tap_mid, s1_pix_reg};
    assign fwd     = s1_valid_reg && (s1_addr_reg == ic);

    always_ff @(posedge clk)
    begin
        if (en && s1_valid_reg)
        begin
            line_mem[s1_addr_reg] <= wr_data;
        end
        if (accept)
        begin
            rd_data_reg <= fwd ? wr_data : line_mem[ic];
        end
    end

    // Window shifts left by one column and takes the new column on the right.
    always_comb
    begin
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            win_new[r][0] = window_reg[r][1];
            win_new[r][1] = window_reg[r][2];
        end
        win_new[0][2] = tap_top;
        win_new[1][2] = tap_mid;
        win_new[2][2] = s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (en && s1_valid_reg)
        begin
            window_reg <= win_new;
        end
    end

    // Kernel arithmetic and output register.
    rgbc_kernel_mac #(
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s1_valid_reg && s1_emit_reg),
        .window      (win_new),
        .mask        (s1_mask_reg),
        .coef_top    (coef_top_reg),
        .coef_middle (coef_middle_reg),
        .coef_bottom (coef_bottom_reg),
        .out_valid   (m_axis_tvalid),
        .out_data    (m_axis_tdata),
        .out_last    (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> design/rgbc_checker.sv
// Port-level checks for rgb_3x3_convolution, attached by the bind at the end.
// Depends on rgbc_pkg and on the top level's port names.
`default_nettype none

module rgbc_checker
    import rgbc_pkg::*;
(
    input wire                  clk,
    input wire                  rst_n,
    input wire                  s_axis_tvalid,
    input wire                  s_axis_tready,
    input wire                  m_axis_tvalid,
    input wire                  m_axis_tready,
    input wire [PIX_BUS_W-1:0]  m_axis_tdata,
    input wire                  m_axis_tlast
);

    // A result that is held back keeps its data and frame marker.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // With the output register empty the block always takes a pixel.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // A downstream that takes results never stalls the input.
    a_ready_follows_sink: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is drained");

    // A stalled input is only ever caused by a waiting result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a waiting result");

endmodule

bind rgb_3x3_convolution rgbc_checker u_rgbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
